>>> hdl/lmcs_pkg.sv
// ----------------------------------------------------------------------------
// lmcs_pkg
// Shared types and constants for the LED matrix column scanner.
// ----------------------------------------------------------------------------
package lmcs_pkg;

	localparam int DATA_W  = 8;   // one byte per column
	localparam int ROWS    = 7;   // rows wired on the matrix
	localparam int SCAN_W  = 5;   // full width of a scan column index
	localparam int ROW_OUT = 7;   // row lines driven out

	localparam logic [2:0] OP_TICK  = 3'd0;
	localparam logic [2:0] OP_DRAW  = 3'd1;
	localparam logic [2:0] OP_CLEAR = 3'd2;
	localparam logic [2:0] OP_SWAP  = 3'd3;
	localparam logic [2:0] OP_LOAD  = 3'd4;

	typedef struct packed {
		logic [2:0]        op;
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic              color;
		logic [7:0]        col_bits;
	} cmd_t;

	typedef struct packed {
		logic [6:0] row_drive;
		logic [2:0] col_addr;
		logic       select_low;
		logic       select_high;
	} res_t;

	// strobes from the sequencer to one buffer memory
	typedef struct packed {
		logic rd_en;
		logic wr_en;
		logic clr;
	} buf_ctl_t;

endpackage

>>> hdl/lmcs_buf.sv
// ----------------------------------------------------------------------------
// lmcs_buf
// Column buffer: synchronous memory with registered read data, one write and
// one read port, per-entry valid bits so that reset and clear act at once.
// ----------------------------------------------------------------------------
module lmcs_buf
	import lmcs_pkg::*;
#(
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  buf_ctl_t          ctl,
	input  logic [AW-1:0]     raddr,
	input  logic [AW-1:0]     waddr,
	input  logic [DATA_W-1:0] wdata,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [DEPTH];
	logic [DEPTH-1:0]  vld_q;
	logic [DATA_W-1:0] rdata_q;
	logic              rvld_q;

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[waddr] <= wdata;
		end
		if (ctl.rd_en) begin
			rdata_q <= mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			rvld_q <= 1'b0;
		end else begin
			if (ctl.clr) begin
				vld_q <= '0;
			end else if (ctl.wr_en) begin
				vld_q[waddr] <= 1'b1;
			end
			if (ctl.rd_en) begin
				rvld_q <= vld_q[raddr];
			end
		end
	end

	// never-written entries read as zero
	assign rdata = rdata_q & {DATA_W{rvld_q}};

`ifndef SYNTHESIS
	a_no_clr_wr: assert property (@(posedge clk) disable iff (!arst_n)
		!(ctl.clr && ctl.wr_en))
		else $error("clear and write in the same cycle");
	a_clr_empties: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.clr |=> (vld_q == '0))
		else $error("valid bits survived a clear");
	a_wr_marks: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.wr_en && !ctl.clr) |=> vld_q[$past(waddr)])
		else $error("written entry not marked valid");
`endif

endmodule

>>> hdl/lmcs_ctrl.sv
// ----------------------------------------------------------------------------
// lmcs_ctrl
// Sequencer: takes transactions, drives read-modify-write on the draw buffer,
// the swap copy sweep, and the scan counter and tick result.
// ----------------------------------------------------------------------------
module lmcs_ctrl
	import lmcs_pkg::*;
#(
	parameter int COLS = 16,
	parameter int AW   = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  cmd_t              cmd,
	output res_t              result,
	output logic              result_strobe,
	output buf_ctl_t          draw_ctl,
	output logic [AW-1:0]     draw_raddr,
	output logic [AW-1:0]     draw_waddr,
	output logic [DATA_W-1:0] draw_wdata,
	input  logic [DATA_W-1:0] draw_rdata,
	output buf_ctl_t          shown_ctl,
	output logic [AW-1:0]     shown_raddr,
	output logic [AW-1:0]     shown_waddr,
	output logic [DATA_W-1:0] shown_wdata,
	input  logic [DATA_W-1:0] shown_rdata
);

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_EXEC  = 4'b0010,
		S_COPY  = 4'b0100,
		S_DRAIN = 4'b1000
	} state_t;

	state_t            state_q;
	logic [AW-1:0]     scan_q;
	logic [AW-1:0]     cnt_q;
	logic [2:0]        op_s1;
	logic              ok_s1;
	logic [AW-1:0]     idx_s1;
	logic [DATA_W-1:0] mask_s1;
	logic              color_s1;
	logic [DATA_W-1:0] bits_s1;
	logic [AW-1:0]     col_s1;
	logic              wpend_s1;
	logic [AW-1:0]     waddr_s1;

	logic              accept;
	logic              x_ok;
	logic              y_ok;
	logic              cmd_ok;
	logic [AW-1:0]     x_idx;
	logic [SCAN_W-1:0] col_ext;
	logic              exec_draw;
	logic              exec_load;

	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;

	assign x_ok   = !cmd.x[15] && (cmd.x[14:0] < 15'(COLS));
	assign y_ok   = !cmd.y[15] && (cmd.y[14:0] < 15'(ROWS));
	assign cmd_ok = (cmd.op == OP_DRAW) ? (x_ok && y_ok) : x_ok;
	assign x_idx  = cmd.x[AW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			scan_q   <= '0;
			cnt_q    <= '0;
			wpend_s1 <= 1'b0;
			op_s1    <= OP_TICK;
			ok_s1    <= 1'b0;
		end else begin
			// each sweep read is written back in the next cycle
			wpend_s1 <= (state_q == S_COPY);
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						op_s1 <= cmd.op;
						ok_s1 <= cmd_ok;
						if (cmd.op == OP_SWAP) begin
							cnt_q   <= '0;
							state_q <= S_COPY;
						end else begin
							state_q <= S_EXEC;
						end
						if (cmd.op == OP_TICK) begin
							scan_q <= (scan_q == AW'(COLS - 1)) ? '0 : scan_q + 1'b1;
						end
					end
				end
				S_EXEC: begin
					state_q <= S_IDLE;
				end
				S_COPY: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == AW'(COLS - 1)) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// payload of the accepted transaction
	always_ff @(posedge clk) begin
		if (accept) begin
			idx_s1   <= x_idx;
			mask_s1  <= DATA_W'(1) << cmd.y[2:0];
			color_s1 <= cmd.color;
			bits_s1  <= cmd.col_bits;
			col_s1   <= scan_q;
		end
		if (state_q == S_COPY) begin
			waddr_s1 <= cnt_q;
		end
	end

	assign exec_draw = (state_q == S_EXEC) && (op_s1 == OP_DRAW) && ok_s1;
	assign exec_load = (state_q == S_EXEC) && (op_s1 == OP_LOAD) && ok_s1;

	// draw buffer: read at accept or during the sweep, write back in EXEC
	always_comb begin
		draw_ctl.rd_en = (accept && (cmd.op == OP_DRAW) && cmd_ok) || (state_q == S_COPY);
		draw_ctl.wr_en = exec_draw || exec_load;
		draw_ctl.clr   = (state_q == S_EXEC) && (op_s1 == OP_CLEAR);
		draw_raddr     = (state_q == S_COPY) ? cnt_q : x_idx;
		draw_waddr     = idx_s1;
		if (exec_load) begin
			draw_wdata = bits_s1;
		end else if (color_s1) begin
			draw_wdata = draw_rdata | mask_s1;
		end else begin
			draw_wdata = draw_rdata & ~mask_s1;
		end
	end

	// display buffer: tick reads, sweep writes in the cycle after its read
	always_comb begin
		shown_ctl.rd_en = accept && (cmd.op == OP_TICK);
		shown_ctl.wr_en = wpend_s1;
		shown_ctl.clr   = 1'b0;
		shown_raddr     = scan_q;
		shown_waddr     = waddr_s1;
		shown_wdata     = draw_rdata;
	end

	assign col_ext              = SCAN_W'(col_s1);
	assign result_strobe        = (state_q == S_EXEC) && (op_s1 == OP_TICK);
	assign result.row_drive     = shown_rdata[ROW_OUT-1:0];
	assign result.col_addr      = col_ext[2:0];
	assign result.select_low    = (col_ext < SCAN_W'(8));
	assign result.select_high   = (col_ext >= SCAN_W'(8)) && (col_ext < SCAN_W'(16));

`ifndef SYNTHESIS
	a_strobe_after_tick: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe |-> $past(start && !busy && (cmd.op == OP_TICK)))
		else $error("result without a tick transaction");
	a_scan_range: assert property (@(posedge clk) disable iff (!arst_n)
		scan_q <= AW'(COLS - 1))
		else $error("scan column out of range");
	a_draw_port: assert property (@(posedge clk) disable iff (!arst_n)
		!(draw_ctl.rd_en && draw_ctl.wr_en))
		else $error("draw buffer read and written together");
	a_copy_busy: assert property (@(posedge clk) disable iff (!arst_n)
		shown_ctl.wr_en |-> busy)
		else $error("display buffer written while idle");
`endif

endmodule

>>> hdl/led_matrix_column_scanner.sv
// ----------------------------------------------------------------------------
// led_matrix_column_scanner
// Double-buffered LED matrix column multiplexer, top level.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low. For tick, draw
// pixel, clear and load column, the buffer memory is
// read in the accept cycle and written back (or the tick result shown) in
// the next, so busy is high for one cycle. Swap walks the draw buffer into
// the display buffer one column per cycle through the single read port,
// with busy high through the sweep and its drain state. A tick result appears on
// result with result_strobe high for exactly one cycle, the cycle after the
// tick is accepted; it is not held, so the receiver must take it then. Other
// operations give no result. Both buffers read as zero after reset and the
// draw buffer after a clear, at once: per-column valid bits, no clearing pass.
// ----------------------------------------------------------------------------
module led_matrix_column_scanner
	import lmcs_pkg::*;
#(
	parameter int COLS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  cmd_t cmd,
	output res_t result,
	output logic result_strobe
);

	// address width for the column buffers
	localparam int AW = (COLS > 1) ? $clog2(COLS) : 1;

	buf_ctl_t          draw_ctl;
	logic [AW-1:0]     draw_raddr;
	logic [AW-1:0]     draw_waddr;
	logic [DATA_W-1:0] draw_wdata;
	logic [DATA_W-1:0] draw_rdata;
	buf_ctl_t          shown_ctl;
	logic [AW-1:0]     shown_raddr;
	logic [AW-1:0]     shown_waddr;
	logic [DATA_W-1:0] shown_wdata;
	logic [DATA_W-1:0] shown_rdata;

	// sequencer: handshake, scan counter, read-modify-write and copy sweep
	lmcs_ctrl #(
		.COLS (COLS),
		.AW   (AW)
	) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.cmd           (cmd),
		.result        (result),
		.result_strobe (result_strobe),
		.draw_ctl      (draw_ctl),
		.draw_raddr    (draw_raddr),
		.draw_waddr    (draw_waddr),
		.draw_wdata    (draw_wdata),
		.draw_rdata    (draw_rdata),
		.shown_ctl     (shown_ctl),
		.shown_raddr   (shown_raddr),
		.shown_waddr   (shown_waddr),
		.shown_wdata   (shown_wdata),
		.shown_rdata   (shown_rdata)
	);

	// draw buffer: pixel writes, loads and clears land here
	lmcs_buf #(
		.DEPTH (COLS),
		.AW    (AW)
	) u_draw (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (draw_ctl),
		.raddr  (draw_raddr),
		.waddr  (draw_waddr),
		.wdata  (draw_wdata),
		.rdata  (draw_rdata)
	);

	// display buffer: scanned by ticks, refreshed only by a swap
	lmcs_buf #(
		.DEPTH (COLS),
		.AW    (AW)
	) u_shown (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (shown_ctl),
		.raddr  (shown_raddr),
		.waddr  (shown_waddr),
		.wdata  (shown_wdata),
		.rdata  (shown_rdata)
	);

endmodule

>>> bench/lmcs_column_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmcs_column_checker
// Watches the command and result channels of the column scanner, keeps its
// own copy of both column buffers and the scan position, and checks every
// tick result against the predicted column.
// ----------------------------------------------------------------------------
module lmcs_column_checker
	import lmcs_pkg::*;
#(
	parameter int COLS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic busy,
	input  cmd_t cmd,
	input  res_t result,
	input  logic result_strobe,
	output int   failures,
	output int   outstanding
);

	logic [DATA_W-1:0] draw_buf  [COLS];
	logic [DATA_W-1:0] shown_buf [COLS];
	int unsigned       scan_col;
	res_t              expected_scans [$];
	int                errs;

	task automatic note_failure(input string msg);
		if (errs < 10)
			$display("[%0t] mismatch: %s", $realtime, msg);
		errs++;
	endtask

	// Apply one accepted transaction to the local buffers; ticks queue a column.
	task automatic model_command(input cmd_t c);
		int   px;
		int   py;
		res_t scan;
		px = $signed(c.x);
		py = $signed(c.y);
		case (c.op)
			OP_TICK: begin
				scan.row_drive   = shown_buf[scan_col][ROW_OUT-1:0];
				scan.col_addr    = scan_col[2:0];
				scan.select_low  = (scan_col < 8);
				scan.select_high = (scan_col >= 8) && (scan_col < 16);
				expected_scans.push_back(scan);
				scan_col = (scan_col + 1) % COLS;
			end
			OP_DRAW: begin
				if (px >= 0 && px < COLS && py >= 0 && py < ROWS)
					draw_buf[px][py] = c.color;
			end
			OP_CLEAR: begin
				for (int i = 0; i < COLS; i++)
					draw_buf[i] = '0;
			end
			OP_SWAP: begin
				for (int i = 0; i < COLS; i++)
					shown_buf[i] = draw_buf[i];
			end
			OP_LOAD: begin
				if (px >= 0 && px < COLS)
					draw_buf[px] = c.col_bits;
			end
			default: ;
		endcase
	endtask

	task automatic check_result(input res_t got);
		res_t want;
		if (expected_scans.size() == 0) begin
			note_failure($sformatf("result with none pending: rows=%h addr=%0d lo=%b hi=%b",
				got.row_drive, got.col_addr, got.select_low, got.select_high));
		end else begin
			want = expected_scans.pop_front();
			if (got.row_drive !== want.row_drive || got.col_addr !== want.col_addr ||
					got.select_low !== want.select_low ||
					got.select_high !== want.select_high)
				note_failure($sformatf(
					"exp rows=%h addr=%0d lo=%b hi=%b, got rows=%h addr=%0d lo=%b hi=%b",
					want.row_drive, want.col_addr, want.select_low, want.select_high,
					got.row_drive, got.col_addr, got.select_low, got.select_high));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < COLS; i++) begin
				draw_buf[i]  = '0;
				shown_buf[i] = '0;
			end
			scan_col = 0;
			expected_scans.delete();
			errs = 0;
			failures    <= 0;
			outstanding <= 0;
		end else begin
			// result first: it belongs to a transaction taken on an earlier edge
			if (result_strobe)
				check_result(result);
			if (start && !busy)
				model_command(cmd);
			failures    <= errs;
			outstanding <= expected_scans.size();
		end
	end

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Bench for the LED matrix column scanner: directed corner cases, then a
// long random mix of commands with random idle gaps; a checker beside the
// block predicts and compares every tick result.
// ----------------------------------------------------------------------------
module tb_top
	import lmcs_pkg::*;
();

	localparam int COLS = 16;

	// op codes the block decodes to nothing
	localparam logic [2:0] OP_SPARE_5 = 3'd5;
	localparam logic [2:0] OP_SPARE_6 = 3'd6;
	localparam logic [2:0] OP_SPARE_7 = 3'd7;

	localparam int RANDOM_ITEMS = 1050;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	cmd_t cmd;
	res_t result;
	logic result_strobe;
	int   failures;
	int   outstanding;

	// when set, the sender runs back to back for a stretch
	bit   burst;

	led_matrix_column_scanner #(.COLS(COLS)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.result(result),
		.result_strobe(result_strobe)
	);

	lmcs_column_checker #(.COLS(COLS)) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.result(result),
		.result_strobe(result_strobe),
		.failures(failures),
		.outstanding(outstanding)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	function automatic cmd_t make_cmd(input logic [2:0] op, input int x, input int y,
			input logic color, input logic [7:0] bits);
		cmd_t c;
		c.op       = op;
		c.x        = x[15:0];
		c.y        = y[15:0];
		c.color    = color;
		c.col_bits = bits;
		return c;
	endfunction

	// Coordinate: mostly on the matrix, sometimes just off either edge,
	// sometimes anything in the 16-bit range.
	function automatic logic [15:0] pick_coord(input int span);
		int          r;
		logic [15:0] v;
		r = $urandom_range(0, 9);
		v = 16'($urandom);
		if (r < 7)
			v = 16'($urandom_range(0, span - 1));
		else if (r == 7)
			v = 16'($urandom_range(span, span + 2));
		else if (r == 8)
			v = 16'(-$urandom_range(1, 2));
		return v;
	endfunction

	// Random command; ticks dominate so the scan keeps moving through the
	// display buffer, and clears are rare so the buffers fill up.
	function automatic cmd_t random_command();
		cmd_t c;
		int   r;
		c.x        = 16'($urandom);
		c.y        = 16'($urandom);
		c.color    = 1'($urandom);
		c.col_bits = 8'($urandom);
		r = $urandom_range(0, 99);
		if (r < 40) begin
			c.op = OP_TICK;
		end else if (r < 66) begin
			c.op = OP_DRAW;
			c.x  = pick_coord(COLS);
			c.y  = pick_coord(ROWS);
		end else if (r < 78) begin
			c.op = OP_LOAD;
			c.x  = pick_coord(COLS);
		end else if (r < 86) begin
			c.op = OP_SWAP;
		end else if (r < 89) begin
			c.op = OP_CLEAR;
		end else if (r < 94) begin
			c.op = 3'($urandom_range(OP_SPARE_5, OP_SPARE_7));
		end else begin
			c.op = OP_TICK;
		end
		return c;
	endfunction

	// Send one transaction. Entered and left at a falling edge; start is
	// lowered only when a gap follows, so back-to-back items keep it high.
	task automatic issue(input cmd_t c);
		int gap;
		gap = burst ? 0 : $urandom_range(0, 15);
		if (gap > 0) begin
			start <= 1'b0;
			cmd   <= random_command();   // noise on the bus while idle
			repeat (gap) @(negedge clk);
		end
		start <= 1'b1;
		cmd   <= c;
		// taken at the first rising edge that sees busy low
		do @(posedge clk); while (busy);
		@(negedge clk);
	endtask

	initial begin
		arst_n = 1'b0;
		start  = 1'b0;
		cmd    = '0;
		burst  = 1'b0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// ---- directed part ----
		issue(make_cmd(OP_TICK, 0, 0, 1'b0, 8'h00));          // blank display, column 0
		issue(make_cmd(OP_DRAW, 0, 0, 1'b1, 8'h00));          // corner pixel
		issue(make_cmd(OP_DRAW, 15, 6, 1'b1, 8'h00));         // opposite corner
		issue(make_cmd(OP_DRAW, 16, 0, 1'b1, 8'hFF));         // off the right edge
		issue(make_cmd(OP_DRAW, -1, 3, 1'b1, 8'hFF));         // off the left edge
		issue(make_cmd(OP_DRAW, 3, 7, 1'b1, 8'hFF));          // row past the last one
		issue(make_cmd(OP_DRAW, 3, -32768, 1'b1, 8'hFF));     // most negative row
		issue(make_cmd(OP_DRAW, 32767, 32767, 1'b1, 8'hFF));  // most positive both
		issue(make_cmd(OP_LOAD, -32768, 0, 1'b1, 8'hFF));     // load off the matrix
		issue(make_cmd(OP_LOAD, 7, 0, 1'b0, 8'hFF));          // full byte, bit 7 not driven
		issue(make_cmd(OP_LOAD, 16, 0, 1'b0, 8'hAA));         // load just past the end
		issue(make_cmd(OP_LOAD, 9, -1, 1'b1, 8'h55));
		issue(make_cmd(OP_SPARE_5, 2, 2, 1'b1, 8'hFF));       // unused codes do nothing
		issue(make_cmd(OP_SPARE_6, 4, 1, 1'b1, 8'hFF));
		issue(make_cmd(OP_SPARE_7, -1, -1, 1'b1, 8'hFF));
		issue(make_cmd(OP_SWAP, 0, 0, 1'b0, 8'h00));
		issue(make_cmd(OP_DRAW, 7, 6, 1'b0, 8'h00));          // darken a lit pixel
		// walk the scan past column 7 into the upper bank
		repeat (9)
			issue(make_cmd(OP_TICK, 0, 0, 1'b0, 8'h00));
		issue(make_cmd(OP_CLEAR, 0, 0, 1'b0, 8'h00));
		issue(make_cmd(OP_SWAP, 0, 0, 1'b0, 8'h00));
		issue(make_cmd(OP_TICK, 0, 0, 1'b0, 8'h00));

		// ---- random part ----
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			// switch between gappy and back-to-back stretches now and then
			if (n % 64 == 0)
				burst = ($urandom_range(0, 2) == 0);
			issue(random_command());
		end
		start <= 1'b0;

		// drain: last tick result, then room for a swap still in flight
		while (outstanding != 0)
			@(negedge clk);
		repeat (COLS + 4) @(negedge clk);

		if (failures == 0 && outstanding == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	// hang guard, far beyond the slowest legal run
	initial begin
		#1_000_000;
		$display("Verification failed");
		$finish;
	end

endmodule
